FILE: sv/ray_box_slab_test_top_assert.svh
// Assertion macros for the ray/box slab test block.
// Used by the port-level checker; no other dependencies.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define RBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is also checked during reset.
`define RBST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/rbst_pkg.sv
// Shared types and constants for the ray/box slab test block.
// No dependencies.
`timescale 1ns / 1ps

package rbst_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } cfg_reg_e;

  // Per-axis flags that ride alongside the dividers.
  typedef struct packed {
    logic dz;        // direction component is zero
    logic out_slab;  // origin outside the slab (matters only when dz)
    logic dneg;      // direction negative: swap entry/exit
    logic neg_lo;    // quotient for the lower corner is negative
    logic neg_up;    // quotient for the upper corner is negative
  } axis_flags_t;

endpackage

FILE: sv/rbst_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Quotient of (num << FRAC_BITS) / den; standalone, no package use.
`timescale 1ns / 1ps

module rbst_div #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [COORD_WIDTH:0]                 num_i,
  input  logic [COORD_WIDTH-1:0]               den_i,
  output logic [COORD_WIDTH+FRAC_BITS:0]       quo_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + 1 + FRAC_BITS;

  logic [W-1:0]  rem_q [QW];
  logic [QW-1:0] qn_q  [QW];
  logic [W-1:0]  den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [QW-1:0] qn_in;
    logic [W-1:0]  den_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign qn_in  = QW'(num_i) << FRAC_BITS;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign qn_in  = qn_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, qn_in[QW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        qn_q[k]  <= {qn_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = qn_q[QW-1];

endmodule

FILE: sv/ray_box_slab_test_top.sv
// Coordinates are Q16.16 by default. Pipeline: input, corners, operands, then the
// bit-per-stage divider pipelines (six in parallel, one per corner and axis).
// Throughput: one item per cycle; the whole pipeline holds while the output
// item is stalled. Reset clears all valid bits and loads the box to [0, 1.0].
// Timing: asynchronous active-low reset on control and box registers.
`timescale 1ns / 1ps

module ray_box_slab_test_top
  import rbst_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] t_start_i,
  input  logic signed [COORD_WIDTH-1:0] t_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + 1 + FRAC_BITS;
  localparam logic [W-1:0]  ONE_FX  = W'(1) << FRAC_BITS;
  localparam logic [QW-1:0] TOP_Q   = QW'(1) << (W - 1);
  localparam logic [W-1:0]  MIN_FX  = W'(1) << (W - 1);
  localparam logic [W-1:0]  MAX_FX  = ~MIN_FX;

  logic en;

  // ---------------- configuration ----------------
  logic signed [W-1:0] box_lo_q [3];
  logic signed [W-1:0] box_hi_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo_q[i] <= '0;
        box_hi_q[i] <= ONE_FX;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BOX_LOW_X:  box_lo_q[0] <= cfg_data_i;
        REG_BOX_LOW_Y:  box_lo_q[1] <= cfg_data_i;
        REG_BOX_LOW_Z:  box_lo_q[2] <= cfg_data_i;
        REG_BOX_HIGH_X: box_hi_q[0] <= cfg_data_i;
        REG_BOX_HIGH_Y: box_hi_q[1] <= cfg_data_i;
        REG_BOX_HIGH_Z: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: input register ----------------
  logic                a_vld_q;
  logic signed [W-1:0] a_org_q [3];
  logic signed [W-1:0] a_dir_q [3];
  logic signed [W-1:0] a_tlo_q, a_thi_q;

  // ---------------- stage B: ordered corners ----------------
  logic                b_vld_q;
  logic signed [W-1:0] b_lo_q [3];
  logic signed [W-1:0] b_up_q [3];
  logic signed [W-1:0] b_org_q [3];
  logic signed [W-1:0] b_dir_q [3];
  logic signed [W-1:0] b_tlo_q, b_thi_q;

  // ---------------- stage C: divider operands ----------------
  logic                c_vld_q;
  logic [W:0]          c_num_lo_q [3];
  logic [W:0]          c_num_up_q [3];
  logic [W-1:0]        c_den_q [3];
  axis_flags_t         c_fl_q [3];
  logic signed [W-1:0] c_tlo_q, c_thi_q;

  // side pipe parallel to the dividers
  logic                sb_vld_q [QW];
  axis_flags_t         sb_fl_q  [QW][3];
  logic signed [W-1:0] sb_tlo_q [QW];
  logic signed [W-1:0] sb_thi_q [QW];

  // axis stages: index 0 is the saturation stage, 1..3 narrow x, y, z
  logic                s_vld_q [4];
  logic                s_hit_q [4];
  logic signed [W-1:0] s_tlo_q [4];
  logic signed [W-1:0] s_thi_q [4];
  logic signed [W-1:0] s_e0_q  [4][3];
  logic signed [W-1:0] s_e1_q  [4][3];
  axis_flags_t         s_fl_q  [4][3];

  assign out_valid_o = s_vld_q[3];
  assign hit_o       = s_hit_q[3];
  assign en          = !(s_vld_q[3] && out_stall_i);
  assign in_stall_o  = !en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      for (int k = 0; k < QW; k++) sb_vld_q[k] <= 1'b0;
      for (int k = 0; k < 4; k++)  s_vld_q[k]  <= 1'b0;
    end else if (en) begin
      a_vld_q     <= in_valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      sb_vld_q[0] <= c_vld_q;
      for (int k = 1; k < QW; k++) sb_vld_q[k] <= sb_vld_q[k-1];
      s_vld_q[0]  <= sb_vld_q[QW-1];
      for (int k = 1; k < 4; k++)  s_vld_q[k]  <= s_vld_q[k-1];
    end
  end

  // stage A and B payload, plus the stage C t range
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_org_q[0] <= origin_x_i;
      a_org_q[1] <= origin_y_i;
      a_org_q[2] <= origin_z_i;
      a_dir_q[0] <= dir_x_i;
      a_dir_q[1] <= dir_y_i;
      a_dir_q[2] <= dir_z_i;
      a_tlo_q    <= t_start_i;
      a_thi_q    <= t_end_i;
      for (int i = 0; i < 3; i++) begin
        b_lo_q[i]  <= (box_lo_q[i] < box_hi_q[i]) ? box_lo_q[i] : box_hi_q[i];
        b_up_q[i]  <= (box_lo_q[i] < box_hi_q[i]) ? box_hi_q[i] : box_lo_q[i];
        b_org_q[i] <= a_org_q[i];
        b_dir_q[i] <= a_dir_q[i];
      end
      b_tlo_q <= a_tlo_q;
      b_thi_q <= a_thi_q;
      c_tlo_q <= b_tlo_q;
      c_thi_q <= b_thi_q;
    end
  end

  logic [QW-1:0] q_lo [3];
  logic [QW-1:0] q_up [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [W:0] diff_lo, diff_up;
    logic              dneg;

    // stage B -> C: corner minus origin as magnitude plus sign
    always_comb begin
      diff_lo = {b_lo_q[i][W-1], b_lo_q[i]} - {b_org_q[i][W-1], b_org_q[i]};
      diff_up = {b_up_q[i][W-1], b_up_q[i]} - {b_org_q[i][W-1], b_org_q[i]};
      dneg    = b_dir_q[i][W-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_num_lo_q[i]       <= diff_lo[W] ? -diff_lo : diff_lo;
        c_num_up_q[i]       <= diff_up[W] ? -diff_up : diff_up;
        c_den_q[i]          <= dneg ? -b_dir_q[i] : b_dir_q[i];
        c_fl_q[i].dz        <= (b_dir_q[i] == '0);
        c_fl_q[i].out_slab  <= (b_org_q[i] < b_lo_q[i]) || (b_org_q[i] > b_up_q[i]);
        c_fl_q[i].dneg      <= dneg;
        c_fl_q[i].neg_lo    <= diff_lo[W] ^ dneg;
        c_fl_q[i].neg_up    <= diff_up[W] ^ dneg;
      end
    end

    rbst_div #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (c_num_lo_q[i]),
      .den_i (c_den_q[i]),
      .quo_o (q_lo[i])
    );

    rbst_div #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div_up (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (c_num_up_q[i]),
      .den_i (c_den_q[i]),
      .quo_o (q_up[i])
    );

    // saturate to the signed coordinate range
    logic [W-1:0] t_lo, t_up;
    axis_flags_t  fl;
    always_comb begin
      fl = sb_fl_q[QW-1][i];
      if (q_lo[i] >= TOP_Q) t_lo = fl.neg_lo ? MIN_FX : MAX_FX;
      else                  t_lo = fl.neg_lo ? -q_lo[i][W-1:0] : q_lo[i][W-1:0];
      if (q_up[i] >= TOP_Q) t_up = fl.neg_up ? MIN_FX : MAX_FX;
      else                  t_up = fl.neg_up ? -q_up[i][W-1:0] : q_up[i][W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_e0_q[0][i] <= fl.dneg ? t_up : t_lo;
        s_e1_q[0][i] <= fl.dneg ? t_lo : t_up;
        s_fl_q[0][i] <= fl;
      end
    end
  end

  // side pipe
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_fl_q[0]  <= c_fl_q;
      sb_tlo_q[0] <= c_tlo_q;
      sb_thi_q[0] <= c_thi_q;
      for (int k = 1; k < QW; k++) begin
        sb_fl_q[k]  <= sb_fl_q[k-1];
        sb_tlo_q[k] <= sb_tlo_q[k-1];
        sb_thi_q[k] <= sb_thi_q[k-1];
      end
      s_tlo_q[0] <= sb_tlo_q[QW-1];
      s_thi_q[0] <= sb_thi_q[QW-1];
      s_hit_q[0] <= 1'b1;
    end
  end

  // narrowing, one axis per stage
  for (genvar a = 0; a < 3; a++) begin : g_narrow
    logic signed [W-1:0] tlo_n, thi_n;
    logic                hit_n;
    axis_flags_t         fl;
    always_comb begin
      fl    = s_fl_q[a][a];
      tlo_n = s_tlo_q[a];
      thi_n = s_thi_q[a];
      hit_n = s_hit_q[a];
      if (!fl.dz) begin
        if (s_e0_q[a][a] > tlo_n) tlo_n = s_e0_q[a][a];
        if (s_e1_q[a][a] < thi_n) thi_n = s_e1_q[a][a];
      end else if (fl.out_slab) begin
        hit_n = 1'b0;
      end
      if (thi_n <= tlo_n) hit_n = 1'b0;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_tlo_q[a+1] <= tlo_n;
        s_thi_q[a+1] <= thi_n;
        s_hit_q[a+1] <= hit_n;
        s_e0_q[a+1]  <= s_e0_q[a];
        s_e1_q[a+1]  <= s_e1_q[a];
        s_fl_q[a+1]  <= s_fl_q[a];
      end
    end
  end

endmodule

FILE: sv/rbst_checker.sv
// Port-level checker for ray_box_slab_test_top, bound to the top level.
// Uses the assertion macros in ray_box_slab_test_top_assert.svh.
`timescale 1ns / 1ps
`include "ray_box_slab_test_top_assert.svh"

module rbst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_ready_o,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);

  `RBST_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "config port not ready")
  `RBST_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "bad input stall")
  `RBST_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "stalled item dropped")
  `RBST_ASSERT(a_hit_hold, (out_valid_o && out_stall_i) |=> $stable(hit_o), "stalled hit changed")

endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o)
);
